FILE: rtl/svpwm3s_pkg.sv
// Shared types, constants and helpers for the three-shunt SVPWM duty block.
// No dependencies; every module of the block imports this package.
package svpwm3s_pkg;

  localparam int PeriodW = 14;
  localparam int CfgW    = 16;
  localparam int CompW   = 16;
  localparam int ProdW   = 33;   // signed 16 x unsigned 16 product
  localparam int WideW   = 36;   // headroom for three-term sums

  // Configuration register indexes
  localparam logic [2:0] REG_CARRIER_PERIOD = 3'd0;
  localparam logic [2:0] REG_PERIOD_SCALE   = 3'd1;
  localparam logic [2:0] REG_SCALE_SQRT3    = 3'd2;
  localparam logic [2:0] REG_WIN_AFTER      = 3'd3;
  localparam logic [2:0] REG_WIN_BEFORE     = 3'd4;

  // Sector codes (sector 1 through sector 6)
  localparam logic [2:0] SEC_1 = 3'd0;
  localparam logic [2:0] SEC_2 = 3'd1;
  localparam logic [2:0] SEC_3 = 3'd2;
  localparam logic [2:0] SEC_4 = 3'd3;
  localparam logic [2:0] SEC_5 = 3'd4;
  localparam logic [2:0] SEC_6 = 3'd5;

  // Sampled phase pair codes
  localparam logic [1:0] PH_VW = 2'd0;
  localparam logic [1:0] PH_UW = 2'd1;
  localparam logic [1:0] PH_UV = 2'd2;

  typedef struct packed {
    logic [PeriodW-1:0] carrier_period;
    logic [CfgW-1:0]    period_scale;
    logic [CfgW-1:0]    period_scale_sqrt3;
    logic [CfgW-1:0]    window_after;
    logic [CfgW-1:0]    window_before;
  } cfg_t;

  typedef struct packed {
    logic signed [ProdW-1:0] ua;
    logic signed [ProdW-1:0] ub;
  } prod_t;

  typedef struct packed {
    logic [CompW-1:0] a;
    logic [CompW-1:0] b;
    logic [CompW-1:0] c;
    logic [2:0]       sec;
  } duty_t;

  // Signed division by 2**k that truncates toward zero.
  function automatic logic signed [WideW-1:0] trunc_shr(input logic signed [WideW-1:0] n,
                                                        input logic [4:0] k);
    logic signed [WideW-1:0] bias;
    bias = n[WideW-1] ? ~({WideW{1'b1}} << k) : '0;
    return (n + bias) >>> k;
  endfunction

endpackage

FILE: rtl/svpwm3s_scale.sv
// Input register and scaling multipliers of the SVPWM duty block.
// Depends on svpwm3s_pkg.
module svpwm3s_scale import svpwm3s_pkg::*; (
  input  logic                    clk,
  input  logic [1:0]              en,
  input  cfg_t                    cfg,
  input  logic signed [CompW-1:0] volt_alpha,
  input  logic signed [CompW-1:0] volt_beta,
  output prod_t                   prod
);

  logic signed [CompW-1:0] alpha;
  logic signed [CompW-1:0] beta;
  logic signed [ProdW-1:0] ua_next;
  logic signed [ProdW-1:0] bt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      alpha <= volt_alpha;
      beta  <= volt_beta;
    end
  end

  assign ua_next = ProdW'(alpha) * ProdW'($signed({1'b0, cfg.period_scale_sqrt3}));
  assign bt      = ProdW'(beta) * ProdW'($signed({1'b0, cfg.period_scale}));

  // beta is negated; the product never reaches the most negative code
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod.ua <= ua_next;
      prod.ub <= -bt;
    end
  end

endmodule

FILE: rtl/svpwm3s_duty.sv
// Sector choice and phase compare values of the SVPWM duty block.
// Depends on svpwm3s_pkg; fed by svpwm3s_scale.
module svpwm3s_duty import svpwm3s_pkg::*; (
  input  logic       clk,
  input  logic [2:0] en,
  input  cfg_t       cfg,
  input  prod_t      prod,
  output duty_t      duty
);

  logic signed [WideW-1:0] x;
  logic signed [WideW-1:0] y;
  logic signed [WideW-1:0] z;
  logic [2:0]              sec;
  logic signed [WideW-1:0] y_next;
  logic signed [WideW-1:0] z_next;
  logic [2:0]              sec_next;
  logic                    x_le0;

  logic [CompW-1:0]        a;
  logic [CompW-1:0]        qx;
  logic [CompW-1:0]        qy;
  logic [CompW-1:0]        qz;
  logic [2:0]              sec_d;
  logic signed [WideW-1:0] t_wide;
  logic signed [WideW-1:0] n;
  logic signed [WideW-1:0] qa;
  logic [CompW-1:0]        a_next;
  logic [CompW-1:0]        b_next;
  logic [CompW-1:0]        c_next;

  // X, Y, Z and sector
  assign y_next = trunc_shr(WideW'(prod.ub) + WideW'(prod.ua), 5'd1);
  assign z_next = trunc_shr(WideW'(prod.ub) - WideW'(prod.ua), 5'd1);
  assign x_le0  = prod.ub[ProdW-1] || (prod.ub == '0);

  always_comb begin
    if (y_next[WideW-1]) begin
      if (z_next[WideW-1]) sec_next = SEC_5;
      else                 sec_next = x_le0 ? SEC_4 : SEC_3;
    end else begin
      if (!z_next[WideW-1]) sec_next = SEC_2;
      else                  sec_next = x_le0 ? SEC_6 : SEC_1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x   <= WideW'(prod.ub);
      y   <= y_next;
      z   <= z_next;
      sec <= sec_next;
    end
  end

  // Phase A compare and the scaled X, Y, Z steps
  assign t_wide = $signed({{(WideW-CfgW){1'b0}}, cfg.period_scale});

  always_comb begin
    case (sec) inside
      SEC_1, SEC_4: n = t_wide + x - z;
      SEC_2, SEC_5: n = t_wide + y - z;
      default:      n = t_wide - x + y;
    endcase
  end

  assign qa     = trunc_shr(n, 5'd18);
  assign a_next = CompW'(cfg.period_scale >> 3) + qa[CompW-1:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a     <= a_next;
      qx    <= CompW'(trunc_shr(x, 5'd17));
      qy    <= CompW'(trunc_shr(y, 5'd17));
      qz    <= CompW'(trunc_shr(z, 5'd17));
      sec_d <= sec;
    end
  end

  // Phases B and C
  always_comb begin
    case (sec_d) inside
      SEC_1, SEC_4: begin
        b_next = a + qz;
        c_next = b_next - qx;
      end
      SEC_2, SEC_5: begin
        b_next = a + qz;
        c_next = a - qy;
      end
      default: begin
        c_next = a - qy;
        b_next = c_next + qx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      duty.a   <= a;
      duty.b   <= b_next;
      duty.c   <= c_next;
      duty.sec <= sec_d;
    end
  end

endmodule

FILE: rtl/svpwm3s_trig.sv
// ADC trigger placement and result register of the SVPWM duty block.
// Depends on svpwm3s_pkg; fed by svpwm3s_duty.
module svpwm3s_trig import svpwm3s_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  cfg_t             cfg,
  input  duty_t            duty,
  output logic [CompW-1:0] duty_a,
  output logic [CompW-1:0] duty_b,
  output logic [CompW-1:0] duty_c,
  output logic [CompW-1:0] adc_trigger,
  output logic             trigger_falling,
  output logic [2:0]       sector,
  output logic [1:0]       sampled_phases
);

  logic [CompW-1:0] e;
  logic [CompW-1:0] o;
  logic [1:0]       phases_next;
  logic [CompW-1:0] p;
  logic [CompW-1:0] gap;
  logic [CompW-1:0] d;
  logic [CompW-1:0] trig_next;
  logic             fall_next;

  // Reference and neighbour phase per sector
  always_comb begin
    case (duty.sec)
      SEC_1:   begin e = duty.a; o = duty.b; phases_next = PH_VW; end
      SEC_2:   begin e = duty.b; o = duty.a; phases_next = PH_UW; end
      SEC_3:   begin e = duty.b; o = duty.c; phases_next = PH_UW; end
      SEC_4:   begin e = duty.c; o = duty.b; phases_next = PH_UV; end
      SEC_5:   begin e = duty.c; o = duty.a; phases_next = PH_UV; end
      default: begin e = duty.a; o = duty.c; phases_next = PH_VW; end
    endcase
  end

  assign p   = CompW'(cfg.carrier_period);
  assign gap = p - e;
  assign d   = e + cfg.window_after;

  always_comb begin
    fall_next = 1'b0;
    if (gap > cfg.window_after) begin
      trig_next = p - 1'b1;
    end else if ({1'b0, e - o} > {gap, 1'b0}) begin
      trig_next = e - cfg.window_before;
    end else if (d >= p) begin
      // fold back past the period end
      fall_next = 1'b1;
      trig_next = (p << 1) - d - 1'b1;
    end else begin
      trig_next = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      duty_a          <= duty.a;
      duty_b          <= duty.b;
      duty_c          <= duty.c;
      adc_trigger     <= trig_next;
      trigger_falling <= fall_next;
      sector          <= duty.sec;
      sampled_phases  <= phases_next;
    end
  end

endmodule

FILE: rtl/svpwm_three_shunt_duty.sv
// Top level of the three-shunt space-vector PWM duty generator.
// Depends on svpwm3s_pkg, svpwm3s_scale, svpwm3s_duty and svpwm3s_trig.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+----------------------------------------
//   input    | in_valid / in_stall         | volt_alpha, volt_beta
//   result   | out_valid / out_stall       | duty_a/b/c, adc_trigger, trigger_falling,
//            |                             | sector, sampled_phases
//   config   | cfg_wen, cfg_index          | cfg_wdata
//
// Six register stages: input, products, X/Y/Z and sector, phase A, phases B/C,
// trigger and result. One transfer per cycle is sustained while out_stall stays low;
// a result is offered once it reaches the last stage. A stage advances when it is
// empty or the stage after it advances, so bubbles collapse; the input stalls only
// when all six stages hold items and the result waits. Reset (rst, synchronous)
// empties the pipeline and loads the default registers.
module svpwm_three_shunt_duty import svpwm3s_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_wen,
  input  logic [2:0]              cfg_index,
  input  logic [CfgW-1:0]         cfg_wdata,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CompW-1:0] volt_alpha,
  input  logic signed [CompW-1:0] volt_beta,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CompW-1:0]        duty_a,
  output logic [CompW-1:0]        duty_b,
  output logic [CompW-1:0]        duty_c,
  output logic [CompW-1:0]        adc_trigger,
  output logic                    trigger_falling,
  output logic [2:0]              sector,
  output logic [1:0]              sampled_phases
);

  localparam int Stages = 6;

  cfg_t              cfg;
  logic [Stages-1:0] vld;
  logic [Stages-1:0] en;
  logic              blocked;
  prod_t             prod;
  duty_t             duty;

  // Configuration registers; write only while the block is idle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_period     <= PeriodW'(1800);
      cfg.period_scale       <= CfgW'(7200);
      cfg.period_scale_sqrt3 <= CfgW'(12470);
      cfg.window_after       <= CfgW'(100);
      cfg.window_before      <= CfgW'(50);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_CARRIER_PERIOD: cfg.carrier_period     <= cfg_wdata[PeriodW-1:0];
        REG_PERIOD_SCALE:   cfg.period_scale       <= cfg_wdata;
        REG_SCALE_SQRT3:    cfg.period_scale_sqrt3 <= cfg_wdata;
        REG_WIN_AFTER:      cfg.window_after       <= cfg_wdata;
        REG_WIN_BEFORE:     cfg.window_before      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads unless it and every stage after it are full
  // and the result is held
  always_comb begin
    blocked = out_stall;
    for (int k = Stages - 1; k >= 0; k--) begin
      blocked = blocked && vld[k];
      en[k]   = !blocked;
    end
  end

  // Advance valid bits with their stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[Stages-1];

  svpwm3s_scale u_scale (
    .clk        (clk),
    .en         (en[1:0]),
    .cfg        (cfg),
    .volt_alpha (volt_alpha),
    .volt_beta  (volt_beta),
    .prod       (prod)
  );

  svpwm3s_duty u_duty (
    .clk  (clk),
    .en   (en[4:2]),
    .cfg  (cfg),
    .prod (prod),
    .duty (duty)
  );

  svpwm3s_trig u_trig (
    .clk             (clk),
    .en              (en[5]),
    .cfg             (cfg),
    .duty            (duty),
    .duty_a          (duty_a),
    .duty_b          (duty_b),
    .duty_c          (duty_c),
    .adc_trigger     (adc_trigger),
    .trigger_falling (trigger_falling),
    .sector          (sector),
    .sampled_phases  (sampled_phases)
  );

endmodule

FILE: verif/svpwm_three_shunt_duty_tb.sv
// Self-checking testbench for the three-shunt SVPWM duty generator.
// Depends on svpwm3s_pkg and svpwm_three_shunt_duty; predicts in place every
// result not typed in; checks each result transfer against the oldest one.
module svpwm_three_shunt_duty_tb import svpwm3s_pkg::*; ();

  // Scaled terms are divided by this to form the compare offsets.
  localparam longint CompDiv = 131072;
  // Receiver hold-off that fills the pipeline and stalls the input.
  localparam int HoldCycles = 300;
  // Cycles without any transfer before the run is declared hung.
  localparam int WatchdogLimit = 4000;
  // Settling time at the end so that any stray result can still come back.
  localparam int SettleCycles = 12;
  localparam int RandomPerPhase = 265;
  localparam int DirCount = 21;

  typedef struct packed {
    logic [CompW-1:0] duty_a;
    logic [CompW-1:0] duty_b;
    logic [CompW-1:0] duty_c;
    logic [CompW-1:0] trig;
    logic             falling;
    logic [2:0]       sec;
    logic [1:0]       phases;
  } svm_out_t;

  typedef struct packed {
    logic signed [CompW-1:0] alpha;
    logic signed [CompW-1:0] beta;
    logic                    known;
    svm_out_t                want;
  } vec_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wen = 1'b0;
  logic [2:0]              cfg_index = REG_CARRIER_PERIOD;
  logic [CfgW-1:0]         cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [CompW-1:0] volt_alpha = '0;
  logic signed [CompW-1:0] volt_beta = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [CompW-1:0]        duty_a;
  logic [CompW-1:0]        duty_b;
  logic [CompW-1:0]        duty_c;
  logic [CompW-1:0]        adc_trigger;
  logic                    trigger_falling;
  logic [2:0]              sector;
  logic [1:0]              sampled_phases;

  // Mirror of the block's registers, loaded with the reset values.
  logic [PeriodW-1:0] shadow_period = 14'd1800;
  logic [CfgW-1:0]    shadow_scale = 16'd7200;
  logic [CfgW-1:0]    shadow_rt3 = 16'd12470;
  logic [CfgW-1:0]    shadow_win_after = 16'd100;
  logic [CfgW-1:0]    shadow_win_before = 16'd50;

  svm_out_t pending_duty_q[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int err_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int setting_count = 0;

  // Directed commands: extremes of both fields, unit steps around zero on
  // every sign combination, alternating bit patterns and a few mid values.
  // Only the all-zero command at reset settings has its result typed in.
  vec_row_t directed_tbl [DirCount] = '{
    '{16'sd0, 16'sd0, 1'b1,
      '{16'd900, 16'd900, 16'd900, 16'd1799, 1'b0, SEC_2, PH_UW}},
    '{16'sd32767, 16'sd0, 1'b0, '0},
    '{16'sh8000, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd32767, 1'b0, '0},
    '{16'sd0, 16'sh8000, 1'b0, '0},
    '{16'sd32767, 16'sd32767, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sd32767, 16'sh8000, 1'b0, '0},
    '{16'sh8000, 16'sd32767, 1'b0, '0},
    '{16'sd1, 16'sd0, 1'b0, '0},
    '{-16'sd1, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd1, 1'b0, '0},
    '{16'sd0, -16'sd1, 1'b0, '0},
    '{16'sd1, 16'sd1, 1'b0, '0},
    '{-16'sd1, -16'sd1, 1'b0, '0},
    '{16'sd1, -16'sd1, 1'b0, '0},
    '{-16'sd1, 16'sd1, 1'b0, '0},
    '{16'sh5555, 16'shAAAA, 1'b0, '0},
    '{16'shAAAA, 16'sh5555, 1'b0, '0},
    '{16'sd16000, -16'sd9000, 1'b0, '0},
    '{-16'sd12000, 16'sd20000, 1'b0, '0}
  };

  svpwm_three_shunt_duty i_dut (
    .clk, .rst,
    .cfg_wen, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .volt_alpha, .volt_beta,
    .out_valid, .out_stall,
    .duty_a, .duty_b, .duty_c, .adc_trigger, .trigger_falling, .sector, .sampled_phases
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Compute the duty triple, sector, ADC trigger and sampled pair for one
  // command under the current register mirror.
  function automatic svm_out_t predict_duty(logic signed [CompW-1:0] alpha,
                                            logic signed [CompW-1:0] beta);
    longint t, k, ua, ub, x, y, z, base;
    logic [CompW-1:0] e, o, gap, diff, d;
    svm_out_t r;
    t = shadow_scale;
    k = shadow_rt3;
    ua = longint'(alpha) * k;
    ub = -(longint'(beta) * t);
    x = ub;
    y = (ub + ua) / 2;
    z = (ub - ua) / 2;
    base = t / 8;

    if (y < 0) r.sec = (z < 0) ? SEC_5 : ((x <= 0) ? SEC_4 : SEC_3);
    else r.sec = (z >= 0) ? SEC_2 : ((x <= 0) ? SEC_6 : SEC_1);

    // Offsets are signed; keep the running compare value signed as well.
    case (r.sec) inside
      SEC_1, SEC_4: begin
        r.duty_a = 16'(base + ((t + x - z) / 2) / CompDiv);
        r.duty_b = 16'(longint'(r.duty_a) + z / CompDiv);
        r.duty_c = 16'(longint'(r.duty_b) - x / CompDiv);
      end
      SEC_2, SEC_5: begin
        r.duty_a = 16'(base + ((t + y - z) / 2) / CompDiv);
        r.duty_b = 16'(longint'(r.duty_a) + z / CompDiv);
        r.duty_c = 16'(longint'(r.duty_a) - y / CompDiv);
      end
      default: begin
        r.duty_a = 16'(base + ((t - x + y) / 2) / CompDiv);
        r.duty_c = 16'(longint'(r.duty_a) - y / CompDiv);
        r.duty_b = 16'(longint'(r.duty_c) + x / CompDiv);
      end
    endcase

    // Reference phase edge and its neighbor for the trigger placement.
    case (r.sec)
      SEC_1: begin
        e = r.duty_a; o = r.duty_b; r.phases = PH_VW;
      end
      SEC_2: begin
        e = r.duty_b; o = r.duty_a; r.phases = PH_UW;
      end
      SEC_3: begin
        e = r.duty_b; o = r.duty_c; r.phases = PH_UW;
      end
      SEC_4: begin
        e = r.duty_c; o = r.duty_b; r.phases = PH_UV;
      end
      SEC_5: begin
        e = r.duty_c; o = r.duty_a; r.phases = PH_UV;
      end
      default: begin
        e = r.duty_a; o = r.duty_c; r.phases = PH_VW;
      end
    endcase

    gap = shadow_period - e;
    diff = e - o;
    r.falling = 1'b0;
    if (gap > shadow_win_after) begin
      // wide gap: sample just before the period ends
      r.trig = shadow_period - 16'd1;
    end else if ({1'b0, diff} > {gap, 1'b0}) begin
      // long pulse: sample ahead of the edge
      r.trig = e - shadow_win_before;
    end else begin
      // after the edge, folded back onto the falling ramp if past the period
      d = e + shadow_win_after;
      if (d >= shadow_period) begin
        r.falling = 1'b1;
        r.trig = {shadow_period, 1'b0} - d - 16'd1;
      end else begin
        r.trig = d;
      end
    end
    return r;
  endfunction

  // Offer one command, idling first at the sender's rate, and record the
  // expected result at the edge where the transfer happens.
  task automatic push_command(logic signed [CompW-1:0] alpha, logic signed [CompW-1:0] beta,
                              logic known, svm_out_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    volt_alpha <= alpha;
    volt_beta <= beta;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_duty_q.push_back(known ? want : predict_duty(alpha, beta));
    sent_count++;
  endtask

  // Mostly full-range commands; some near zero to hit the sector sign
  // boundaries, some at the field extremes.
  task automatic push_random(int n);
    logic signed [CompW-1:0] alpha, beta;
    int sel;
    repeat (n) begin
      sel = $urandom_range(7);
      if (sel == 0) begin
        alpha = CompW'($urandom_range(4) - 2);
        beta = CompW'($urandom_range(4) - 2);
      end else if (sel == 1) begin
        alpha = ($urandom_range(1) != 0) ? 16'sh8000 : 16'sh7FFF;
        beta = ($urandom_range(2) == 0) ? 16'sh8000 : CompW'($urandom);
      end else begin
        alpha = CompW'($urandom);
        beta = CompW'($urandom);
      end
      push_command(alpha, beta, 1'b0, '0);
    end
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_duty_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CfgW-1:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_CARRIER_PERIOD: shadow_period = data[PeriodW-1:0];
      REG_PERIOD_SCALE:   shadow_scale = data;
      REG_SCALE_SQRT3:    shadow_rt3 = data;
      REG_WIN_AFTER:      shadow_win_after = data;
      REG_WIN_BEFORE:     shadow_win_before = data;
      default: ;
    endcase
  endtask

  // Load all five registers, plus a write to an unmapped index that the
  // block must ignore. Only called with the pipeline empty.
  task automatic program_regs(logic [CfgW-1:0] period, logic [CfgW-1:0] scale,
                              logic [CfgW-1:0] rt3, logic [CfgW-1:0] win_after,
                              logic [CfgW-1:0] win_before);
    write_reg(REG_CARRIER_PERIOD, period);
    write_reg(REG_PERIOD_SCALE, scale);
    write_reg(REG_SCALE_SQRT3, rt3);
    write_reg(REG_WIN_AFTER, win_after);
    write_reg(REG_WIN_BEFORE, win_before);
    write_reg(3'(REG_WIN_BEFORE + $urandom_range(3, 1)), CfgW'($urandom));
    cfg_wen <= 1'b0;
    setting_count++;
  endtask

  // Either a consistent motor setting (T = 4P, T*sqrt3, windows within a
  // quarter period) or fully random register contents.
  task automatic random_regs();
    logic [CfgW-1:0] period, scale;
    period = CfgW'($urandom_range(16383, 1));
    scale = 16'(4 * period);
    if ($urandom_range(1) != 0) begin
      program_regs(period, scale, 16'((scale * 1732) / 1000),
                   CfgW'($urandom_range(period / 4)), CfgW'($urandom_range(period / 4)));
    end else begin
      program_regs(CfgW'($urandom), CfgW'($urandom), CfgW'($urandom),
                   CfgW'($urandom), CfgW'($urandom));
    end
  endtask

  task automatic check_field(string label, logic [CompW-1:0] want, logic [CompW-1:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      err_count++;
    end
  endtask

  // Receiver: random stalls at the current rate, except for one long
  // hold-off on request that lets the pipeline fill and back up the input.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // Check each result transfer against the oldest prediction.
  always @(posedge clk) begin : result_check
    svm_out_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_duty_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got duty %0d/%0d/%0d trig %0d",
                 $time, duty_a, duty_b, duty_c, adc_trigger);
        err_count++;
      end else begin
        want = pending_duty_q.pop_front();
        check_field("duty_a", want.duty_a, duty_a);
        check_field("duty_b", want.duty_b, duty_b);
        check_field("duty_c", want.duty_c, duty_c);
        check_field("adc_trigger", want.trig, adc_trigger);
        check_field("trigger_falling", CompW'(want.falling), CompW'(trigger_falling));
        check_field("sector", CompW'(want.sec), CompW'(sector));
        check_field("sampled_phases", CompW'(want.phases), CompW'(sampled_phases));
        checked_count++;
      end
    end
  end

  // Watchdog: count cycles without any transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("svpwm_three_shunt_duty verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: directed commands, then random ones.
    src_idle_pct = 32;
    sink_idle_pct = 55;
    for (int i = 0; i < DirCount; i++) begin
      push_command(directed_tbl[i].alpha, directed_tbl[i].beta,
                   directed_tbl[i].known, directed_tbl[i].want);
    end
    push_random(RandomPerPhase);
    drain_pipe();

    // Zero period with every other register at its top value.
    program_regs(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_random(RandomPerPhase);
    drain_pipe();

    // Swap idling rates; largest period (upper bits dropped), smallest rest.
    src_idle_pct = 55;
    sink_idle_pct = 32;
    program_regs(16'hFFFF, 16'd1, 16'd1, 16'd0, 16'd0);
    push_random(RandomPerPhase);
    drain_pipe();

    random_regs();
    push_random(RandomPerPhase);
    drain_pipe();

    // No idling; short period so the fold-back and long-pulse placements
    // are frequent. Start the receiver hold-off while the sender keeps going.
    src_idle_pct = 0;
    sink_idle_pct = 0;
    program_regs(16'd100, 16'd400, 16'd693, 16'd40, 16'd10);
    hold_req <= 1'b1;
    push_random(RandomPerPhase);
    drain_pipe();

    random_regs();
    push_random(RandomPerPhase);
    drain_pipe();

    // Let any stray result show up before closing.
    repeat (SettleCycles) @(posedge clk);
    $display("Sent %0d commands (%0d directed) under %0d register settings plus reset values;",
             sent_count, DirCount, setting_count);
    $display("checked %0d results, %0d mismatches.", checked_count, err_count);
    if (err_count == 0) begin
      $display("svpwm_three_shunt_duty verification clean");
    end else begin
      $display("svpwm_three_shunt_duty verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/svpwm3s_pkg.sv
rtl/svpwm3s_scale.sv
rtl/svpwm3s_duty.sv
rtl/svpwm3s_trig.sv
rtl/svpwm_three_shunt_duty.sv
verif/svpwm_three_shunt_duty_tb.sv
